FILE: sv/sha1_pkg.sv
`default_nettype none

package sha1_pkg;

    typedef logic [31:0] t_word;

    // Working variables of the compression rounds.
    typedef struct packed {
        t_word a;
        t_word b;
        t_word c;
        t_word d;
        t_word e;
    } t_abcde;

    localparam int unsigned NUM_WORDS  = 5;
    localparam int unsigned NUM_ROUNDS = 80;

    localparam t_word H_INIT [0:NUM_WORDS-1] = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };

    localparam t_word K_0 = 32'h5A827999;
    localparam t_word K_1 = 32'h6ED9EBA1;
    localparam t_word K_2 = 32'h8F1BBCDC;
    localparam t_word K_3 = 32'hCA62C1D6;

    localparam logic [7:0] PAD_MARK = 8'h80;
    localparam logic [5:0] LEN_POS  = 6'd56;
    localparam logic [5:0] FILL_END = 6'd63;
    localparam logic [6:0] ROUND_END = 7'd79;
    localparam logic [2:0] LAST_IDX = 3'd4;

    function automatic t_word rotl(input t_word x, input int unsigned s);
        rotl = (x << s) | (x >> (32 - s));
    endfunction

endpackage

`default_nettype wire

FILE: sv/sha1_round.sv
`default_nettype none

// One SHA-1 round: selects f and K from the round number and forms the new
// working variables.
module sha1_round
    import sha1_pkg::*;
(
    input  wire logic [6:0] i_round,
    input  wire t_word      i_w,
    input  wire t_abcde     i_vars,
    output t_abcde          o_vars
);

    t_word f;
    t_word k;
    t_word t;

    always_comb begin
        if (i_round < 7'd20) begin
            f = (i_vars.b & i_vars.c) | (~i_vars.b & i_vars.d);
            k = K_0;
        end else if (i_round < 7'd40) begin
            f = i_vars.b ^ i_vars.c ^ i_vars.d;
            k = K_1;
        end else if (i_round < 7'd60) begin
            f = (i_vars.b & i_vars.c) | (i_vars.b & i_vars.d) | (i_vars.c & i_vars.d);
            k = K_2;
        end else begin
            f = i_vars.b ^ i_vars.c ^ i_vars.d;
            k = K_3;
        end
        t = rotl(i_vars.a, 5) + f + i_vars.e + k + i_w;
        o_vars.a = t;
        o_vars.b = i_vars.a;
        o_vars.c = rotl(i_vars.b, 30);
        o_vars.d = i_vars.c;
        o_vars.e = i_vars.d;
    end

endmodule

`default_nettype wire

FILE: sv/sha1_hasher.sv
`default_nettype none
// Message bytes are taken only while the hasher is idle; every full 64-byte block
// then takes 80 rounds on the shared round unit plus one chaining add.
// End of message: the padding bytes follow, each final block is compressed the same
// way, then the five digest words leave one per cycle while m_axis_tready is high.
// Reset (synchronous, active low) loads the initial hash and clears all counts.

// Streaming SHA-1 hasher.
//
// The 64-byte block buffer is a single 512-bit shift register. Bytes shift in
// at the low end, so after 64 bytes the first message word sits in the top 32
// bits. During compression the same register acts as the 16-word message
// schedule window: each round consumes the oldest word from the top and shifts
// the newly expanded word in at the bottom. After 80 rounds the buffer holds
// schedule words that are never read again, which is harmless because the
// next block overwrites all 64 bytes before compressing.
//
// Padding is generated one byte per cycle through the same byte path: the
// marker byte, zeros until byte 56, then the 64-bit bit length taken from a
// shift register loaded when the end of message is seen. When the marker lands
// at byte 56 or later, the length does not fit; that block is closed with
// zeros and the length goes into one more block. r_tail marks the block that
// carries the length.
module sha1_hasher
    import sha1_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Input byte stream.
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  wire logic        s_axis_tuser,   // [0] has_byte
    input  wire logic        s_axis_tlast,   // end_of_message
    // Digest word stream.
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,   // [31:0] digest_word
    output logic [2:0]       m_axis_tuser,   // [2:0] word_index
    output logic             m_axis_tlast    // last_word
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PAD,
        S_COMP,
        S_FIN,
        S_OUT
    } t_state;

    t_state        r_state;
    logic [511:0]  r_buf;
    logic [5:0]    r_fill;
    logic [63:0]   r_len;
    logic [63:0]   r_lbits;
    logic          r_pad;
    logic          r_first;
    logic          r_tail;
    logic          r_last;
    logic [6:0]    r_round;
    logic [2:0]    r_oidx;
    t_abcde        r_work;
    t_word         r_h [0:NUM_WORDS-1];

    logic [63:0]   n_len;
    logic [7:0]    pad_byte;
    t_word         w_new;
    t_abcde        round_out;

    // Schedule window taps: word i is the i-th oldest of the sixteen.
    function automatic t_word win(input logic [511:0] b, input int unsigned i);
        win = b[511 - 32*i -: 32];
    endfunction

    assign n_len = r_len + {63'd0, s_axis_tuser};

    always_comb begin
        if (r_first) begin
            pad_byte = PAD_MARK;
        end else if (!r_tail || r_fill < LEN_POS) begin
            pad_byte = 8'h00;
        end else begin
            pad_byte = r_lbits[63:56];
        end
    end

    assign w_new = rotl(win(r_buf, 13) ^ win(r_buf, 8) ^ win(r_buf, 2) ^ win(r_buf, 0), 1);

    sha1_round u_round (
        .i_round (r_round),
        .i_w     (win(r_buf, 0)),
        .i_vars  (r_work),
        .o_vars  (round_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fill  <= '0;
            r_len   <= '0;
            r_pad   <= 1'b0;
            r_first <= 1'b0;
            r_tail  <= 1'b0;
            r_last  <= 1'b0;
            r_round <= '0;
            r_oidx  <= '0;
            for (int i = 0; i < NUM_WORDS; i++) begin
                r_h[i] <= H_INIT[i];
            end
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        if (s_axis_tuser) begin
                            r_buf  <= {r_buf[503:0], s_axis_tdata};
                            r_fill <= r_fill + 6'd1;
                            r_len  <= n_len;
                        end
                        if (s_axis_tlast) begin
                            r_pad   <= 1'b1;
                            r_first <= 1'b1;
                            r_tail  <= 1'b0;
                            r_last  <= 1'b0;
                            r_lbits <= {n_len[60:0], 3'b000};
                        end
                        if (s_axis_tuser && r_fill == FILL_END) begin
                            r_state <= S_COMP;
                            r_work  <= {r_h[0], r_h[1], r_h[2], r_h[3], r_h[4]};
                            r_round <= '0;
                        end else if (s_axis_tlast) begin
                            r_state <= S_PAD;
                        end
                    end
                end
                S_PAD: begin
                    r_buf  <= {r_buf[503:0], pad_byte};
                    r_fill <= r_fill + 6'd1;
                    if (r_first) begin
                        r_first <= 1'b0;
                        // The length fits behind a marker placed before byte 56.
                        if (r_fill < LEN_POS) begin
                            r_tail <= 1'b1;
                        end
                    end else if (r_tail && r_fill >= LEN_POS) begin
                        r_lbits <= {r_lbits[55:0], 8'h00};
                    end
                    if (r_fill == FILL_END) begin
                        // The length's last byte closes the final block; a block
                        // without the length is followed by one that has it.
                        r_last  <= r_tail;
                        r_tail  <= 1'b1;
                        r_state <= S_COMP;
                        r_work  <= {r_h[0], r_h[1], r_h[2], r_h[3], r_h[4]};
                        r_round <= '0;
                    end
                end
                S_COMP: begin
                    r_work  <= round_out;
                    r_buf   <= {r_buf[479:0], w_new};
                    r_round <= r_round + 7'd1;
                    if (r_round == ROUND_END) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    r_h[0] <= r_h[0] + r_work.a;
                    r_h[1] <= r_h[1] + r_work.b;
                    r_h[2] <= r_h[2] + r_work.c;
                    r_h[3] <= r_h[3] + r_work.d;
                    r_h[4] <= r_h[4] + r_work.e;
                    if (!r_pad) begin
                        r_state <= S_IDLE;
                    end else if (r_last) begin
                        r_state <= S_OUT;
                        r_oidx  <= '0;
                    end else begin
                        r_state <= S_PAD;
                    end
                end
                S_OUT: begin
                    if (m_axis_tready) begin
                        if (r_oidx == LAST_IDX) begin
                            // Ready for the next message.
                            for (int i = 0; i < NUM_WORDS; i++) begin
                                r_h[i] <= H_INIT[i];
                            end
                            r_len   <= '0;
                            r_fill  <= '0;
                            r_pad   <= 1'b0;
                            r_last  <= 1'b0;
                            r_state <= S_IDLE;
                        end else begin
                            r_oidx <= r_oidx + 3'd1;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = (r_state == S_OUT);
    assign m_axis_tdata  = r_h[r_oidx];
    assign m_axis_tuser  = r_oidx;
    assign m_axis_tlast  = (r_oidx == LAST_IDX);

endmodule

`default_nettype wire

FILE: sv/sha1_checker.sv
`default_nettype none

module sha1_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic [7:0]  s_axis_tdata,
    input wire logic        s_axis_tuser,
    input wire logic        s_axis_tlast,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [31:0] m_axis_tdata,
    input wire logic [2:0]  m_axis_tuser,
    input wire logic        m_axis_tlast
);

    // No new byte is taken while a digest is being delivered.
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input accepted while digest pending");

    // The last flag marks exactly the fifth word.
    a_last_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser == 3'd4)))
        else $error("last word flag and index disagree");

    // Digest words follow one another without a gap and in order.
    a_idx_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast |=>
            m_axis_tvalid && (m_axis_tuser == $past(m_axis_tuser) + 3'd1))
        else $error("digest word sequence broken");

    // A stalled digest word holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled digest word changed");

endmodule

bind sha1_hasher sha1_checker u_sha1_checker (.*);

`default_nettype wire
